>>> sv/tbp_pkg.sv
// Shared types and constants of the token bucket policer.
// Depends on nothing; used by tbp_retry_div, token_bucket_policer_lru and tb.
package tbp_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int TICKS_SHIFT = 10;

  localparam int RATE_W  = 32;
  localparam int TOK_W   = 32;
  localparam int IDLE_W  = 40;
  localparam int TIME_W  = 48;
  localparam int KEY_W   = 64;
  localparam int KIND_W  = 2;
  localparam int RETRY_W = 17;
  localparam int ADD_W   = 34;
  localparam int CFG_W   = 40;

  localparam logic [ADD_W-1:0]   REFILL_CAP = ADD_W'(64'h2_0000_0000);
  localparam logic [TOK_W-1:0]   ONE_TOKEN  = TOK_W'(65536);
  localparam logic [RETRY_W-1:0] RETRY_MAX  = RETRY_W'(65536);

  localparam logic [KIND_W-1:0] KIND_V4      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_V6      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE   = 2'd3;

  localparam logic [1:0] REG_RATE  = 2'd0;
  localparam logic [1:0] REG_BURST = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;
  localparam logic [1:0] REG_IDLE  = 2'd3;

  localparam logic OP_POLICE = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [KEY_W-1:0]  client_key;
    logic [KIND_W-1:0] key_kind;
    logic [TIME_W-1:0] now_ticks;
  } in_t;

  typedef struct packed {
    logic               allowed;
    logic [RETRY_W-1:0] retry_after_sec;
    logic [CNT_W-1:0]   occupancy;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [KIND_W-1:0] kind;
    logic [TOK_W-1:0]  tokens;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic               busy;
    logic [RETRY_W-1:0] quotient;
  } div_stat_t;

endpackage

>>> sv/tbp_retry_div.sv
// Bit-serial divider for the retry time ceil(65536 / rate), rate below 65536.
// Depends on tbp_pkg.
module tbp_retry_div import tbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [15:0]       divisor,
  output div_stat_t         stat
);

  logic [RETRY_W-1:0] rem_r, rem_nxt;
  logic [RETRY_W-1:0] dvd_r, dvd_nxt;
  logic [RETRY_W-1:0] quo_r, quo_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [15:0]        dsr_r, dsr_nxt;
  logic [RETRY_W-1:0] trial;
  logic               fits;

  assign trial = {rem_r[RETRY_W-2:0], dvd_r[RETRY_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    dsr_nxt = dsr_r;
    if (start) begin
      // dividend 65536 + d - 1 rounds the quotient up
      dvd_nxt = RETRY_W'(32'd65535 + {16'd0, divisor});
      rem_nxt = '0;
      quo_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = 5'(RETRY_W);
    end else if (cnt_r != '0) begin
      rem_nxt = fits ? trial - {1'b0, dsr_r} : trial;
      dvd_nxt = {dvd_r[RETRY_W-2:0], 1'b0};
      quo_nxt = {quo_r[RETRY_W-2:0], fits};
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy     = cnt_r != '0;
  assign stat.quotient = quo_r;

endmodule

>>> sv/token_bucket_policer_lru.sv
// Per-client token bucket policer with a recency-ordered bucket table.
// Depends on tbp_pkg and tbp_retry_div.
//
// One item is in flight at a time. The buckets live in a 4096-entry table
// memory linked oldest to newest through a second memory of next pointers;
// every table read is registered. An item first ages out idle buckets, one
// at a time. A sweep then presents the occupancy, while a request walks the
// buckets in the lookup (up to the occupancy), evicts buckets on a miss, then
// relinks and does the refill arithmetic; a denial with a rate below one
// token per second runs a serial division. The next item is accepted while
// the previous result waits at the output.
// Writing any register empties the table at once; no clearing pass is run.
module token_bucket_policer_lru import tbp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_AGE_RD   = 5'd1;
  localparam logic [4:0] S_AGE_CHK  = 5'd2;
  localparam logic [4:0] S_POST_AGE = 5'd3;
  localparam logic [4:0] S_SR_RD    = 5'd4;
  localparam logic [4:0] S_SR_CHK   = 5'd5;
  localparam logic [4:0] S_EV_RD    = 5'd6;
  localparam logic [4:0] S_EV_DROP  = 5'd7;
  localparam logic [4:0] S_ALLOC    = 5'd8;
  localparam logic [4:0] S_POP      = 5'd9;
  localparam logic [4:0] S_APPEND   = 5'd10;
  localparam logic [4:0] S_HIT_A    = 5'd11;
  localparam logic [4:0] S_HIT_B    = 5'd12;
  localparam logic [4:0] S_ELAP     = 5'd13;
  localparam logic [4:0] S_MUL_LO   = 5'd14;
  localparam logic [4:0] S_MUL_HI   = 5'd15;
  localparam logic [4:0] S_SUM      = 5'd16;
  localparam logic [4:0] S_TOT      = 5'd17;
  localparam logic [4:0] S_DEC      = 5'd18;
  localparam logic [4:0] S_DIV      = 5'd19;
  localparam logic [4:0] S_WB       = 5'd20;
  localparam logic [4:0] S_OUT      = 5'd21;

  // table memories
  entry_t           dmem [TABLE_DEPTH];
  logic [IDX_W-1:0] nmem [TABLE_DEPTH];
  entry_t           dq_r;
  logic [IDX_W-1:0] nq_r;
  logic [IDX_W-1:0] rd_addr;
  logic             nwe;
  logic [IDX_W-1:0] nw_addr, nw_data;
  logic             dwe;
  entry_t           dw_data;

  // configuration
  logic [RATE_W-1:0] rate_r;
  logic [TOK_W-1:0]  burst_r;
  logic [CNT_W-1:0]  limit_r;
  logic [IDLE_W-1:0] idle_r;
  logic [CNT_W-1:0]  eff_lim;

  logic [4:0]        state_r, state_nxt;
  logic              op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic [CNT_W-1:0]  free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]  hwm_r, hwm_nxt;
  logic [IDX_W-1:0]  oldest_r, oldest_nxt;
  logic [IDX_W-1:0]  newest_r, newest_nxt;
  logic [IDX_W-1:0]  free_head_r, free_head_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  prev_r, prev_nxt;
  logic [CNT_W-1:0]  scan_k_r, scan_k_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [IDX_W-1:0]  pred_r, pred_nxt;
  logic [IDX_W-1:0]  hnext_r, hnext_nxt;
  logic [TOK_W-1:0]  tokens_r, tokens_nxt;
  logic [TIME_W-1:0] stamp_r, stamp_nxt;
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic [63:0]       plo_r, plo_nxt;
  logic [47:0]       phi_r, phi_nxt;
  logic [ADD_W-1:0]  add_r, add_nxt;
  logic [TOK_W-1:0]  total_r, total_nxt;
  logic              allowed_r, allowed_nxt;
  logic [RETRY_W-1:0] retry_r, retry_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              div_start;
  div_stat_t         div_stat;

  logic [TIME_W-1:0] age_el;
  logic              key_match;
  logic [64:0]       sum65;
  logic [63-TICKS_SHIFT:0] shifted;
  logic [34:0]       tot35;
  logic [KIND_W-1:0] in_kind;

  tbp_retry_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (rate_r[15:0]),
    .stat    (div_stat)
  );

  assign eff_lim = (limit_r == '0) ? CNT_W'(1) :
                   (limit_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : limit_r;

  assign age_el    = (now_r >= dq_r.stamp) ? now_r - dq_r.stamp : '0;
  assign key_match = (dq_r.key == key_r) && (dq_r.kind == kind_r);
  assign sum65     = {1'b0, phi_r[31:0], 32'd0} + {1'b0, plo_r};
  assign shifted   = sum65[63:TICKS_SHIFT];
  assign tot35     = {3'd0, tokens_r} + {1'b0, add_r};
  assign in_kind   = (in_data.key_kind == KIND_SPARE) ? KIND_UNKNOWN : in_data.key_kind;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    kind_nxt      = kind_r;
    now_nxt       = now_r;
    live_nxt      = live_r;
    free_cnt_nxt  = free_cnt_r;
    hwm_nxt       = hwm_r;
    oldest_nxt    = oldest_r;
    newest_nxt    = newest_r;
    free_head_nxt = free_head_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    scan_k_nxt    = scan_k_r;
    slot_nxt      = slot_r;
    pred_nxt      = pred_r;
    hnext_nxt     = hnext_r;
    tokens_nxt    = tokens_r;
    stamp_nxt     = stamp_r;
    elapsed_nxt   = elapsed_r;
    plo_nxt       = plo_r;
    phi_nxt       = phi_r;
    add_nxt       = add_r;
    total_nxt     = total_r;
    allowed_nxt   = allowed_r;
    retry_nxt     = retry_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_addr       = oldest_r;
    nwe           = 1'b0;
    nw_addr       = oldest_r;
    nw_data       = free_head_r;
    dwe           = 1'b0;
    dw_data       = '{key: key_r, kind: kind_r, tokens: total_r, stamp: now_r};
    div_start     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.op;
          kind_nxt  = in_kind;
          key_nxt   = (in_kind == KIND_UNKNOWN) ? '0 : in_data.client_key;
          now_nxt   = in_data.now_ticks;
          state_nxt = S_AGE_RD;
        end
      end
      S_AGE_RD: begin
        rd_addr   = oldest_r;
        state_nxt = (live_r == '0) ? S_POST_AGE : S_AGE_CHK;
      end
      S_AGE_CHK: begin
        if (age_el > {8'd0, idle_r}) begin
          // drop the oldest bucket onto the free list
          nwe           = 1'b1;
          free_head_nxt = oldest_r;
          free_cnt_nxt  = free_cnt_r + CNT_W'(1);
          oldest_nxt    = nq_r;
          live_nxt      = live_r - CNT_W'(1);
          state_nxt     = S_AGE_RD;
        end else begin
          state_nxt = S_POST_AGE;
        end
      end
      S_POST_AGE: begin
        allowed_nxt = 1'b0;
        retry_nxt   = '0;
        cur_nxt     = oldest_r;
        scan_k_nxt  = '0;
        state_nxt   = (op_r == OP_SWEEP) ? S_OUT : S_SR_RD;
      end
      S_SR_RD: begin
        rd_addr   = cur_r;
        state_nxt = (scan_k_r == live_r) ? S_EV_RD : S_SR_CHK;
      end
      S_SR_CHK: begin
        if (key_match) begin
          slot_nxt   = cur_r;
          pred_nxt   = prev_r;
          hnext_nxt  = nq_r;
          tokens_nxt = dq_r.tokens;
          stamp_nxt  = dq_r.stamp;
          state_nxt  = S_HIT_A;
        end else begin
          prev_nxt   = cur_r;
          cur_nxt    = nq_r;
          scan_k_nxt = scan_k_r + CNT_W'(1);
          state_nxt  = S_SR_RD;
        end
      end
      S_EV_RD: begin
        rd_addr   = oldest_r;
        state_nxt = (live_r >= eff_lim) ? S_EV_DROP : S_ALLOC;
      end
      S_EV_DROP: begin
        nwe           = 1'b1;
        free_head_nxt = oldest_r;
        free_cnt_nxt  = free_cnt_r + CNT_W'(1);
        oldest_nxt    = nq_r;
        live_nxt      = live_r - CNT_W'(1);
        state_nxt     = S_EV_RD;
      end
      S_ALLOC: begin
        rd_addr = free_head_r;
        if (free_cnt_r != '0) begin
          state_nxt = S_POP;
        end else begin
          slot_nxt  = hwm_r[IDX_W-1:0];
          hwm_nxt   = hwm_r + CNT_W'(1);
          state_nxt = S_APPEND;
        end
      end
      S_POP: begin
        slot_nxt      = free_head_r;
        free_head_nxt = nq_r;
        free_cnt_nxt  = free_cnt_r - CNT_W'(1);
        state_nxt     = S_APPEND;
      end
      S_APPEND: begin
        if (live_r == '0) begin
          oldest_nxt = slot_r;
        end else begin
          nwe     = 1'b1;
          nw_addr = newest_r;
          nw_data = slot_r;
        end
        newest_nxt = slot_r;
        live_nxt   = live_r + CNT_W'(1);
        tokens_nxt = burst_r;
        stamp_nxt  = now_r;
        state_nxt  = S_ELAP;
      end
      S_HIT_A: begin
        if (slot_r == newest_r) begin
          state_nxt = S_ELAP;
        end else begin
          // unlink from its place in the recency order
          if (slot_r == oldest_r) begin
            oldest_nxt = hnext_r;
          end else begin
            nwe     = 1'b1;
            nw_addr = pred_r;
            nw_data = hnext_r;
          end
          state_nxt = S_HIT_B;
        end
      end
      S_HIT_B: begin
        nwe        = 1'b1;
        nw_addr    = newest_r;
        nw_data    = slot_r;
        newest_nxt = slot_r;
        state_nxt  = S_ELAP;
      end
      S_ELAP: begin
        elapsed_nxt = (now_r >= stamp_r) ? now_r - stamp_r : '0;
        state_nxt   = S_MUL_LO;
      end
      S_MUL_LO: begin
        plo_nxt   = 64'(elapsed_r[31:0]) * 64'(rate_r);
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        phi_nxt   = 48'(elapsed_r[47:32]) * 48'(rate_r);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if ((phi_r[47:32] != '0) || sum65[64]) begin
          add_nxt = REFILL_CAP;
        end else if (shifted > (63-TICKS_SHIFT+1)'(REFILL_CAP)) begin
          add_nxt = REFILL_CAP;
        end else begin
          add_nxt = shifted[ADD_W-1:0];
        end
        state_nxt = S_TOT;
      end
      S_TOT: begin
        total_nxt = (tot35 > {3'd0, burst_r}) ? burst_r : tot35[TOK_W-1:0];
        state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_WB;
        if (total_r >= ONE_TOKEN) begin
          total_nxt   = total_r - ONE_TOKEN;
          allowed_nxt = 1'b1;
        end else if (rate_r == '0) begin
          retry_nxt = RETRY_MAX;
        end else if (rate_r[31:16] != '0) begin
          retry_nxt = RETRY_W'(1);
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_stat.busy) begin
          retry_nxt = div_stat.quotient;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        dwe       = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{allowed: allowed_r, retry_after_sec: retry_r,
                            occupancy: live_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a register write empties the table
    if (cfg_we) begin
      live_nxt     = '0;
      free_cnt_nxt = '0;
      hwm_nxt      = '0;
      oldest_nxt   = '0;
      newest_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (nwe) begin
      nmem[nw_addr] <= nw_data;
    end
    if (dwe) begin
      dmem[slot_r] <= dw_data;
    end
    dq_r <= dmem[rd_addr];
    nq_r <= nmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      free_cnt_r  <= '0;
      hwm_r       <= '0;
      oldest_r    <= '0;
      newest_r    <= '0;
      out_valid_r <= 1'b0;
      rate_r      <= RATE_W'(13107);
      burst_r     <= TOK_W'(327680);
      limit_r     <= CNT_W'(4096);
      idle_r      <= IDLE_W'(921600);
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      free_cnt_r  <= free_cnt_nxt;
      hwm_r       <= hwm_nxt;
      oldest_r    <= oldest_nxt;
      newest_r    <= newest_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_RATE:  rate_r  <= cfg_wdata[RATE_W-1:0];
          REG_BURST: burst_r <= cfg_wdata[TOK_W-1:0];
          REG_LIMIT: limit_r <= cfg_wdata[CNT_W-1:0];
          REG_IDLE:  idle_r  <= cfg_wdata[IDLE_W-1:0];
          default:   rate_r  <= rate_r;
        endcase
      end
    end
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    kind_r      <= kind_nxt;
    now_r       <= now_nxt;
    free_head_r <= free_head_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    scan_k_r    <= scan_k_nxt;
    slot_r      <= slot_nxt;
    pred_r      <= pred_nxt;
    hnext_r     <= hnext_nxt;
    tokens_r    <= tokens_nxt;
    stamp_r     <= stamp_nxt;
    elapsed_r   <= elapsed_nxt;
    plo_r       <= plo_nxt;
    phi_r       <= phi_nxt;
    add_r       <= add_nxt;
    total_r     <= total_nxt;
    allowed_r   <= allowed_nxt;
    retry_r     <= retry_nxt;
    out_data_r  <= out_data_nxt;
  end

  // every slot handed out is either live or on the free list
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> (live_r + free_cnt_r) == hwm_r)
    else $error("slot accounting mismatch");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CNT_W'(TABLE_DEPTH) && hwm_r <= CNT_W'(TABLE_DEPTH))
    else $error("occupancy beyond table depth");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && !out_stall |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result not presented");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DEC && state_nxt == S_DIV |=> div_stat.busy)
    else $error("retry divider did not start");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SR_CHK |-> scan_k_r < live_r)
    else $error("lookup walked past the live buckets");

endmodule

>>> sim/tb.sv
// Self-checking testbench of the token bucket policer with recency eviction.
// Depends on tbp_pkg and token_bucket_policer_lru; it predicts every result
// with its own bucket table and compares each transaction field by field.
module tb;
  import tbp_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_t              in_data;
  logic             out_valid;
  logic             out_stall;
  out_t             out_data;
  logic             cfg_we;
  logic [1:0]       cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  token_bucket_policer_lru dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Policer settings and bucket table, oldest bucket at the front
  logic [RATE_W-1:0] rate_q;
  logic [TOK_W-1:0]  burst_q;
  logic [12:0]       limit_q;
  logic [IDLE_W-1:0] idle_q;
  entry_t            buckets[$];

  out_t              verdicts[$];
  logic [KEY_W-1:0]  key_pool[256];
  logic [TIME_W-1:0] clock_now;
  bit                calm;
  int                mismatches;
  int                n_sent;
  int                n_checked;
  int                n_allowed;
  int                n_denied;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("timeout: %0d transactions still expected", verdicts.size());
    $display("token_bucket_policer_lru regression: fail");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 11);
  end

  function automatic logic [TIME_W-1:0] since(logic [TIME_W-1:0] now,
                                              logic [TIME_W-1:0] stamp);
    return (now >= stamp) ? now - stamp : '0;
  endfunction

  function automatic out_t police(in_t it);
    out_t             res;
    entry_t           e;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0] key;
    logic [79:0]      prod;
    logic [ADD_W-1:0] add;
    logic [34:0]      total;
    logic [63:0]      quot;
    int               idx;
    int               lim;
    res = '0;
    while (buckets.size() > 0 && since(it.now_ticks, buckets[0].stamp) > idle_q)
      buckets.delete(0);
    if (it.op == OP_POLICE) begin
      kind = (it.key_kind == KIND_SPARE) ? KIND_UNKNOWN : it.key_kind;
      key  = (kind == KIND_UNKNOWN) ? '0 : it.client_key;
      idx = -1;
      foreach (buckets[i])
        if (idx < 0 && buckets[i].kind == kind && buckets[i].key == key) idx = i;
      if (idx >= 0) begin
        e = buckets[idx];
        buckets.delete(idx);
      end else begin
        lim = (limit_q == 0) ? 1 : (limit_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(limit_q);
        while (buckets.size() >= lim) buckets.delete(0);
        e = '{key: key, kind: kind, tokens: burst_q, stamp: it.now_ticks};
      end
      prod  = 80'(since(it.now_ticks, e.stamp)) * 80'(rate_q);
      add   = ((prod >> TICKS_SHIFT) > 80'(REFILL_CAP)) ? REFILL_CAP
                                                         : ADD_W'(prod >> TICKS_SHIFT);
      total = 35'(e.tokens) + 35'(add);
      if (total > 35'(burst_q)) total = 35'(burst_q);
      e.stamp = it.now_ticks;
      if (total >= 35'(ONE_TOKEN)) begin
        total = total - 35'(ONE_TOKEN);
        res.allowed = 1'b1;
      end else if (rate_q == 0) begin
        res.retry_after_sec = RETRY_MAX;
      end else begin
        quot = (64'd65536 + 64'(rate_q) - 64'd1) / 64'(rate_q);
        res.retry_after_sec = (quot < 1) ? RETRY_W'(1) : RETRY_W'(quot);
      end
      e.tokens = TOK_W'(total);
      buckets.insert(buckets.size(), e);
    end
    res.occupancy = CNT_W'(buckets.size());
    return res;
  endfunction

  // Hold valid high after acceptance; the next call lowers it or reloads it
  task automatic send_item(in_t it);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    verdicts.insert(verdicts.size(), police(it));
    n_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    wait (verdicts.size() == 0);
    repeat (30) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_RATE:  rate_q  = val[RATE_W-1:0];
      REG_BURST: burst_q = val[TOK_W-1:0];
      REG_LIMIT: limit_q = val[12:0];
      default:   idle_q  = val[IDLE_W-1:0];
    endcase
    buckets.delete();
  endtask

  task automatic setup(logic [RATE_W-1:0] rate, logic [TOK_W-1:0] burst,
                       logic [12:0] lim, logic [IDLE_W-1:0] idle);
    write_reg(REG_RATE, CFG_W'(rate));
    write_reg(REG_BURST, CFG_W'(burst));
    write_reg(REG_LIMIT, CFG_W'(lim));
    write_reg(REG_IDLE, CFG_W'(idle));
  endtask

  task automatic poke(logic op, logic [KEY_W-1:0] key, logic [KIND_W-1:0] kind,
                      logic [TIME_W-1:0] now);
    in_t it;
    it = '{op: op, client_key: key, key_kind: kind, now_ticks: now};
    send_item(it);
  endtask

  function automatic logic [KIND_W-1:0] KIND_KIND(logic [KEY_W-1:0] key);
    return key[0] ? KIND_V6 : KIND_V4;
  endfunction

  // Mostly well-formed request streams over a key pool, time mostly forward
  task automatic run_traffic(int n, int pool, int max_step);
    in_t it;
    int  r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 3) clock_now = clock_now - TIME_W'($urandom_range(500));
      else if (r < 6) clock_now = clock_now + TIME_W'({$urandom, $urandom} >> 20);
      else clock_now = clock_now + TIME_W'($urandom_range(max_step));
      it.op         = ($urandom_range(99) < 8) ? OP_SWEEP : OP_POLICE;
      it.client_key = key_pool[$urandom_range(pool - 1)];
      it.key_kind   = ($urandom_range(99) < 80) ? KIND_KIND(it.client_key)
                                                : KIND_W'($urandom_range(3));
      it.now_ticks  = clock_now;
      send_item(it);
    end
  endtask

  task automatic test_defaults;
    // burst of 5 tokens drains; a rate of 0.2 token/s gives a 6 s retry
    for (int k = 0; k < 7; k++) poke(OP_POLICE, 64'h0, KIND_V4, 48'd0);
    poke(OP_POLICE, '1, KIND_V6, 48'd0);
    poke(OP_POLICE, 64'h1234, KIND_UNKNOWN, 48'd10);
    poke(OP_POLICE, 64'h9999, KIND_SPARE, 48'd20);
    poke(OP_SWEEP, '1, KIND_SPARE, 48'd30);
    poke(OP_POLICE, 64'h0, KIND_V4, 48'd5);
    poke(OP_POLICE, 64'h0, KIND_V4, 48'd6000);
    poke(OP_SWEEP, 64'h0, KIND_V4, 48'd950000);
    poke(OP_POLICE, '1, KIND_V6, '1);
    poke(OP_POLICE, '1, KIND_V6, 48'd100);
    poke(OP_POLICE, 64'h5555_5555_5555_5555, KIND_V4, 48'd101);
    poke(OP_POLICE, 64'hAAAA_AAAA_AAAA_AAAA, KIND_V6, 48'd102);
  endtask

  task automatic test_edge_settings;
    setup('1, '1, 13'd0, '1);
    clock_now = 0;
    poke(OP_POLICE, 64'h7, KIND_V4, 48'd0);
    poke(OP_POLICE, 64'h8, KIND_V4, 48'd1);
    poke(OP_POLICE, 64'h8, KIND_V4, '1);
    run_traffic(20, 8, 3);
    setup(32'd0, 32'd65536, 13'd8191, 40'd0);
    poke(OP_POLICE, 64'h1, KIND_V4, 48'd0);
    poke(OP_POLICE, 64'h1, KIND_V4, 48'd0);
    poke(OP_POLICE, 64'h1, KIND_V4, 48'd1);
    run_traffic(25, 16, 2);
    setup(32'd1, 32'd65535, 13'd1, 40'd1);
    run_traffic(25, 4, 2);
    setup(32'd65537, 32'd200000, 13'd2, 40'd50);
    run_traffic(30, 6, 30);
    setup(32'd40000, 32'd131072, 13'd4096, 40'hFF_FFFF_FFFF);
    run_traffic(40, 256, 5);
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 8; ph++) begin
      setup($urandom_range(300000, 1), $urandom_range(400000, 65536),
            13'($urandom_range(48, 1)), 40'($urandom_range(4000, 1)));
      calm = (ph == 3);
      run_traffic(100, 24, 60);
    end
    calm = 1'b0;
    setup(32'd13107, 32'd327680, 13'd4096, 40'd921600);
    run_traffic(120, 64, 400);
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; cfg_we = 1'b0;
    cfg_addr = REG_RATE; cfg_wdata = '0; calm = 1'b0;
    mismatches = 0; n_sent = 0; n_checked = 0; n_allowed = 0; n_denied = 0;
    rate_q = 32'd13107; burst_q = 32'd327680; limit_q = 13'd4096;
    idle_q = 40'd921600; clock_now = 0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_defaults;
    test_edge_settings;
    test_random;
    @(negedge clk);
    in_valid = 1'b0;
    wait (verdicts.size() == 0);
    repeat (50) @(posedge clk);
    $display("sent %0d items, checked %0d verdicts (%0d allowed, %0d denied)",
             n_sent, n_checked, n_allowed, n_denied);
    $display("covered reset, extreme and random settings of rate, burst, limit, idle");
    if (mismatches == 0 && verdicts.size() == 0)
      $display("token_bucket_policer_lru regression: pass");
    else
      $display("token_bucket_policer_lru regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict %p", out_data);
      end else begin
        want = verdicts[0];
        verdicts.delete(0);
        n_checked++;
        if (out_data.allowed) n_allowed++; else n_denied++;
        if (out_data.allowed !== want.allowed ||
            out_data.retry_after_sec !== want.retry_after_sec ||
            out_data.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict %0d: expected %p, got %p", n_checked, want, out_data);
        end
      end
    end
  end

endmodule

>>> files.f
sv/tbp_pkg.sv
sv/tbp_retry_div.sv
sv/token_bucket_policer_lru.sv
sim/tb.sv
